[src/assert_macros.svh]
// Assertion macros shared by the calendar time stepper RTL.
// No dependencies; the including module must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a trigger is always followed by the condition in the next cycle.
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

[src/cts_pkg.sv]
// Package for the calendar time stepper: request, command and result types and constants.
// No dependencies; used by the front, back and top modules of the block.
package cts_pkg;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_YEAR   = 3'd1,
    OP_MONTH  = 3'd2,
    OP_DAY    = 3'd3,
    OP_HOUR   = 3'd4,
    OP_MINUTE = 3'd5,
    OP_SECOND = 3'd6,
    OP_LOAD   = 3'd7
  } op_t;

  localparam int YEAR_MAX     = 9999;
  localparam int YEAR_RESET   = 2000;
  localparam int LEAP_CYCLE   = 400;
  localparam int CS_PER_MIN   = 6000;
  localparam int CS_PER_SEC   = 100;
  localparam int MIN_PER_HOUR = 60;
  localparam int HOUR_PER_DAY = 24;

  typedef struct packed {
    logic [2:0]  operation;
    logic        backward;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [12:0] load_centisecond;
  } request_t;

  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [12:0] cur_centisecond;
    logic        out_of_range;
  } result_t;

  // One-hot selection of the unit that a step request moves.
  typedef struct packed {
    logic year;
    logic month;
    logic day;
    logic hour;
    logic minute;
    logic second;
  } unit_t;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    unit_t       unit;
    logic        backward;
    logic        load;
    logic        load_refused;
    logic [8:0]  load_year_mod400;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [12:0] load_centisecond;
  } cmd_t;

endpackage

[src/cts_queue.sv]
// Small register-based first-in first-out queue used between the stages of the block.
// Depends on nothing; width and depth come from parameters (depth of at least two).
module cts_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

[src/cts_front.sv]
// Front stage of the calendar time stepper: decodes requests into commands for the back stage.
// Depends on cts_pkg; feeds the command queue.
module cts_front import cts_pkg::*; (
  input  logic     push,
  output logic     full,
  input  request_t request,
  output logic     cmd_push,
  output cmd_t     cmd,
  input  logic     cmd_full
);

  // Year mod 400 is split as 16 * (year / 16 mod 25) + year mod 16.
  // The mod 25 uses a reciprocal multiply that is exact below 1024.
  localparam int RECIP_25 = 1311;
  localparam int RECIP_SH = 15;

  logic [9:0]  year_hi;
  logic [20:0] prod;
  logic [5:0]  quot;
  logic [10:0] quot_x25;
  logic [4:0]  rem25;
  op_t         op;

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;
  assign op       = op_t'(request.operation);

  always_comb begin
    year_hi  = request.load_year[13:4];
    prod     = 21'(year_hi) * 21'(RECIP_25);
    quot     = prod[RECIP_SH +: 6];
    quot_x25 = 11'(quot) * 11'd25;
    rem25    = 5'(11'(year_hi) - quot_x25);

    cmd                  = '0;
    cmd.backward         = request.backward;
    cmd.load_year_mod400 = {rem25, request.load_year[3:0]};
    cmd.load_year        = request.load_year;
    cmd.load_month       = request.load_month;
    cmd.load_day         = request.load_day;
    cmd.load_hour        = request.load_hour;
    cmd.load_minute      = request.load_minute;
    cmd.load_centisecond = request.load_centisecond;
    case (op)
      OP_NONE:   cmd.unit = '0;
      OP_YEAR:   cmd.unit.year = 1'b1;
      OP_MONTH:  cmd.unit.month = 1'b1;
      OP_DAY:    cmd.unit.day = 1'b1;
      OP_HOUR:   cmd.unit.hour = 1'b1;
      OP_MINUTE: cmd.unit.minute = 1'b1;
      OP_SECOND: cmd.unit.second = 1'b1;
      OP_LOAD: begin
        cmd.load         = 1'b1;
        cmd.load_refused = (request.load_year > 14'(YEAR_MAX));
      end
      default:   cmd.unit = '0;
    endcase
  end

endmodule

[src/cts_back.sv]
// Back stage of the calendar time stepper: holds the date and time and executes commands.
// Depends on cts_pkg; reads the command queue and writes the result queue.
module cts_back import cts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_empty,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  logic [13:0] year;
  logic [3:0]  month;
  logic [5:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [12:0] centisecond;
  logic [8:0]  year_mod400;

  logic [13:0] year_next;
  logic [3:0]  month_next;
  logic [5:0]  day_next;
  logic [4:0]  hour_next;
  logic [5:0]  minute_next;
  logic [12:0] centisecond_next;
  logic [8:0]  year_mod400_next;

  logic signed [15:0] ye;
  logic signed [5:0]  mo;
  logic signed [7:0]  da;
  logic signed [6:0]  ho;
  logic signed [7:0]  mi;
  logic signed [14:0] cs;
  logic signed [7:0]  feb;
  logic [8:0]         mod_step;
  logic               leap;
  logic               year_up;
  logic               year_down;
  logic               refused;
  logic               fire;

  function automatic logic [8:0] mod400_inc(input logic [8:0] v);
    return (v == 9'(LEAP_CYCLE - 1)) ? 9'd0 : v + 9'd1;
  endfunction

  function automatic logic [8:0] mod400_dec(input logic [8:0] v);
    return (v == 9'd0) ? 9'(LEAP_CYCLE - 1) : v - 9'd1;
  endfunction

  assign fire     = !cmd_empty && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;

  always_comb begin
    ye        = $signed({2'b00, year});
    mo        = $signed({2'b00, month});
    da        = $signed({2'b00, day});
    ho        = $signed({2'b00, hour});
    mi        = $signed({2'b00, minute});
    cs        = $signed({2'b00, centisecond});
    mod_step  = year_mod400;
    year_up   = 1'b0;
    year_down = 1'b0;

    // Apply the requested step.
    if (cmd.unit.year) begin
      ye       = cmd.backward ? ye - 16'sd1 : ye + 16'sd1;
      mod_step = cmd.backward ? mod400_dec(year_mod400) : mod400_inc(year_mod400);
    end
    if (cmd.unit.month) begin
      mo = cmd.backward ? mo - 6'sd1 : mo + 6'sd1;
    end
    if (cmd.unit.day) begin
      da = cmd.backward ? da - 8'sd1 : da + 8'sd1;
    end
    if (cmd.unit.hour) begin
      ho = cmd.backward ? ho - 7'sd1 : ho + 7'sd1;
    end
    if (cmd.unit.minute) begin
      mi = cmd.backward ? mi - 8'sd1 : mi + 8'sd1;
    end
    if (cmd.unit.second) begin
      cs = cmd.backward ? cs - 15'(CS_PER_SEC) : cs + 15'(CS_PER_SEC);
    end

    // One carry or borrow pass through the time of day.
    if (cs >= 15'(CS_PER_MIN)) begin
      cs = cs - 15'(CS_PER_MIN);
      mi = mi + 8'sd1;
    end else if (cs < 15'sd0) begin
      cs = cs + 15'(CS_PER_MIN);
      mi = mi - 8'sd1;
    end
    if (mi >= 8'(MIN_PER_HOUR)) begin
      mi = mi - 8'(MIN_PER_HOUR);
      ho = ho + 7'sd1;
    end else if (mi < 8'sd0) begin
      mi = mi + 8'(MIN_PER_HOUR);
      ho = ho - 7'sd1;
    end
    if (ho >= 7'(HOUR_PER_DAY)) begin
      ho = ho - 7'(HOUR_PER_DAY);
      da = da + 8'sd1;
    end else if (ho < 7'sd0) begin
      ho = ho + 7'(HOUR_PER_DAY);
      da = da - 8'sd1;
    end

    // February length from the year after the step, before the month carry.
    leap = (mod_step[1:0] == 2'b00) && !(mod_step inside {9'd100, 9'd200, 9'd300});
    feb  = leap ? 8'sd29 : 8'sd28;

    // The day is corrected once, against the month it currently holds.
    if (mo == 6'sd2) begin
      if (da >= feb + 8'sd1) begin
        da = da - feb;
        mo = mo + 6'sd1;
      end else if (da <= 8'sd0) begin
        da = da + 8'sd31;
        mo = mo - 6'sd1;
      end
    end else if (mo inside {6'sd4, 6'sd6, 6'sd9, 6'sd11}) begin
      if (da >= 8'sd31) begin
        da = da - 8'sd30;
        mo = mo + 6'sd1;
      end else if (da <= 8'sd0) begin
        da = da + 8'sd31;
        mo = mo - 6'sd1;
      end
    end else begin
      if (da >= 8'sd32) begin
        da = da - 8'sd31;
        mo = mo + 6'sd1;
      end else if (da <= 8'sd0) begin
        if (mo inside {6'sd1, 6'sd8}) begin
          da = da + 8'sd31;
        end else if (mo == 6'sd3) begin
          da = da + feb;
        end else begin
          da = da + 8'sd30;
        end
        mo = mo - 6'sd1;
      end
    end

    if (mo >= 6'sd13) begin
      mo      = mo - 6'sd12;
      ye      = ye + 16'sd1;
      year_up = 1'b1;
    end else if (mo <= 6'sd0) begin
      mo        = mo + 6'sd12;
      ye        = ye - 16'sd1;
      year_down = 1'b1;
    end

    // Select the new state and whether the command is refused.
    year_next        = year;
    month_next       = month;
    day_next         = day;
    hour_next        = hour;
    minute_next      = minute;
    centisecond_next = centisecond;
    year_mod400_next = year_mod400;
    if (cmd.load) begin
      refused = cmd.load_refused;
      if (!refused) begin
        year_next        = cmd.load_year;
        month_next       = cmd.load_month;
        day_next         = {1'b0, cmd.load_day};
        hour_next        = cmd.load_hour;
        minute_next      = cmd.load_minute;
        centisecond_next = cmd.load_centisecond;
        year_mod400_next = cmd.load_year_mod400;
      end
    end else begin
      refused = (ye < 16'sd0) || (ye > 16'(YEAR_MAX));
      if (!refused) begin
        year_next        = ye[13:0];
        month_next       = mo[3:0];
        day_next         = da[5:0];
        hour_next        = ho[4:0];
        minute_next      = mi[5:0];
        centisecond_next = cs[12:0];
        if (year_up) begin
          year_mod400_next = mod400_inc(mod_step);
        end else if (year_down) begin
          year_mod400_next = mod400_dec(mod_step);
        end else begin
          year_mod400_next = mod_step;
        end
      end
    end

    res.cur_year        = year_next;
    res.cur_month       = month_next;
    res.cur_day         = day_next[4:0];
    res.cur_hour        = hour_next;
    res.cur_minute      = minute_next;
    res.cur_centisecond = centisecond_next;
    res.out_of_range    = refused;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year        <= 14'(YEAR_RESET);
      month       <= 4'd1;
      day         <= 6'd1;
      hour        <= '0;
      minute      <= '0;
      centisecond <= '0;
      year_mod400 <= 9'(YEAR_RESET % LEAP_CYCLE);
    end else if (fire) begin
      year        <= year_next;
      month       <= month_next;
      day         <= day_next;
      hour        <= hour_next;
      minute      <= minute_next;
      centisecond <= centisecond_next;
      year_mod400 <= year_mod400_next;
    end
  end

endmodule

[src/calendar_time_stepper_top.sv]
// Top level of the calendar time stepper: front decode, command queue, back stage, result queue.
// Depends on cts_pkg, cts_queue, cts_front, cts_back and assert_macros.svh.
//
// The block keeps a Gregorian date and time (year, month, day, hour, minute and
// hundredths of a second). Requests enter like a queue write: a request is taken
// at a clock edge where push is high and full is low. Each request loads a time,
// steps one unit forward or back, or does nothing but run the carry pass. Every
// request produces exactly one result: the time held after it, plus out_of_range
// when the request was refused because the year would leave 0 to 9999.
// Results leave like a queue read: while empty is low the oldest result is on
// the result port, and it is taken at an edge where pop is high.
// A taken request is registered in the command queue; the back stage executes
// it once the result queue has room, and its result waits in the result queue
// for the result port. Throughput is one request per cycle while the result
// queue has room, set by the back stage updating the held date and time per command.
// When the receiver stalls, the result queue fills, then the command queue,
// and only then does full rise; requests are never lost or repeated.
// Reset (synchronous, active high) empties both queues and sets the time to
// January 1st of the year 2000, midnight.
`include "assert_macros.svh"

module calendar_time_stepper_top import cts_pkg::*; #(
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  request_t request,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  cmd_t    front_cmd;
  logic    front_push;
  logic    cmd_full;
  cmd_t    back_cmd;
  logic    cmd_empty;
  logic    cmd_pop;
  result_t back_res;
  logic    res_push;
  logic    res_full;

  // The front decodes each request into a command with a unit select (one-hot for a step, else zero),
  // the load refusal check and the loaded year modulo 400 for the leap rule.
  cts_front u_front (
    .push     (push),
    .full     (full),
    .request  (request),
    .cmd_push (front_push),
    .cmd      (front_cmd),
    .cmd_full (cmd_full)
  );

  // The command queue lets the front keep taking requests while the back waits
  // for room in the result queue.
  cts_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  // The back holds the date and time and executes one command per cycle while the result queue has room.
  cts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // The result queue holds finished results until the receiver pops them.
  cts_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

  // The back stage must never write a result into a full result queue.
  `ASSERT_ALWAYS(a_res_no_overflow, !(res_push && res_full), "result queue overflow")
  // A shown result always carries a year inside the calendar range.
  `ASSERT_ALWAYS(a_year_in_range, empty || (result.cur_year <= 14'(YEAR_MAX)), "year out of range")
  // A request taken at the input is waiting in the command queue in the next cycle.
  `ASSERT_NEXT(a_cmd_lands, push && !full, !cmd_empty, "accepted request lost")
  // A command executed by the back stage shows up as a waiting result.
  `ASSERT_NEXT(a_res_lands, res_push, !empty, "executed command gave no result")

endmodule
